[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define AST_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, quiet during reset
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/shs_pkg.sv]
package shs_pkg;

  localparam int TIMER_W   = 24;
  localparam int COORD_W   = 32;
  localparam int BACKOFF_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 32;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_HOME_TO_MAX  = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_AXIS_REVERSE = cfg_idx_t'(1);
  localparam cfg_idx_t CFG_MIN_POLARITY = cfg_idx_t'(2);
  localparam cfg_idx_t CFG_MAX_POLARITY = cfg_idx_t'(3);
  localparam cfg_idx_t CFG_SEEK_GAP     = cfg_idx_t'(4);
  localparam cfg_idx_t CFG_RELEASE_GAP  = cfg_idx_t'(5);
  localparam cfg_idx_t CFG_BACKOFF      = cfg_idx_t'(6);
  localparam cfg_idx_t CFG_HOME_POS     = cfg_idx_t'(7);

  localparam logic [TIMER_W-1:0] SEEK_GAP_RST    = TIMER_W'(1000);
  localparam logic [TIMER_W-1:0] RELEASE_GAP_RST = TIMER_W'(60000);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SEEK,
    PH_RELEASE,
    PH_BACKOFF
  } phase_t;

endpackage

[src/stepper_homing_sequencer_core.sv]
// result: registered, valid in the cycle after its request is accepted
// throughput: one request per cycle unless a held result is not yet taken; a new request is taken in the same
//   cycle the held result is taken, set by the single result register
// reset: synchronous, active high; sequencer idle, step and dir levels low, error flag clear,
//   configuration and sequencer registers back to their defaults, no result pending; result outputs not reset
`include "assert_macros.svh"
module stepper_homing_sequencer_core #(
  parameter int PULSE_TICKS = 2
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  shs_pkg::cfg_idx_t                  cfg_index,
  input  logic [shs_pkg::CFG_DW-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               cmd,
  input  logic                               min_switch,
  input  logic                               max_switch,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               step_out,
  output logic                               dir_out,
  output logic                               busy_res,
  output logic                               done_res,
  output logic                               error,
  output logic signed [shs_pkg::COORD_W-1:0] position,
  output logic signed [shs_pkg::COORD_W-1:0] home_estimate
);
  import shs_pkg::*;

  localparam logic [TIMER_W-1:0] PulseLoad = TIMER_W'(PULSE_TICKS);

  // configuration registers
  logic                 home_to_max;
  logic                 axis_reverse;
  logic                 min_polarity;
  logic                 max_polarity;
  logic [TIMER_W-1:0]   seek_gap_ticks;
  logic [TIMER_W-1:0]   release_gap_ticks;
  logic [BACKOFF_W-1:0] backoff_steps;
  logic [COORD_W-1:0]   home_position;

  // sequencer state
  phase_t               phase, phase_next;
  logic                 dir_level, dir_level_next;
  logic                 step_level, step_level_next;
  logic                 err_flag, err_flag_next;
  logic [TIMER_W-1:0]   pulse_timer, pulse_timer_next;
  logic [COORD_W-1:0]   net_steps, net_steps_next;
  logic [BACKOFF_W-1:0] backoff_left, backoff_left_next;
  logic [COORD_W-1:0]   position_reg, position_reg_next;
  logic [COORD_W-1:0]   home_estimate_reg, home_estimate_reg_next;
  logic                 done_next;

  logic in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      home_to_max       <= 1'b0;
      axis_reverse      <= 1'b0;
      min_polarity      <= 1'b0;
      max_polarity      <= 1'b0;
      seek_gap_ticks    <= SEEK_GAP_RST;
      release_gap_ticks <= RELEASE_GAP_RST;
      backoff_steps     <= '0;
      home_position     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HOME_TO_MAX:  home_to_max       <= cfg_data[0];
        CFG_AXIS_REVERSE: axis_reverse      <= cfg_data[0];
        CFG_MIN_POLARITY: min_polarity      <= cfg_data[0];
        CFG_MAX_POLARITY: max_polarity      <= cfg_data[0];
        CFG_SEEK_GAP:     seek_gap_ticks    <= cfg_data[TIMER_W-1:0];
        CFG_RELEASE_GAP:  release_gap_ticks <= cfg_data[TIMER_W-1:0];
        CFG_BACKOFF:      backoff_steps     <= cfg_data[BACKOFF_W-1:0];
        CFG_HOME_POS:     home_position     <= cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // next state for one request
  always_comb begin
    logic trig;
    logic go;
    trig = home_to_max ? (max_switch ^ max_polarity) : (min_switch ^ min_polarity);
    go   = 1'b0;

    phase_next             = phase;
    dir_level_next         = dir_level;
    step_level_next        = step_level;
    err_flag_next          = err_flag;
    pulse_timer_next       = pulse_timer;
    net_steps_next         = net_steps;
    backoff_left_next      = backoff_left;
    position_reg_next      = position_reg;
    home_estimate_reg_next = home_estimate_reg;
    done_next              = 1'b0;

    if (cmd) begin
      if (phase != PH_IDLE) begin
        err_flag_next = 1'b1;
      end else begin
        dir_level_next    = ~(axis_reverse ^ home_to_max);
        step_level_next   = 1'b0;
        pulse_timer_next  = PulseLoad;
        net_steps_next    = '0;
        backoff_left_next = '0;
        phase_next        = PH_SEEK;
      end
    end else if (phase != PH_IDLE) begin
      go = 1'b1;
      if (pulse_timer != '0) begin
        pulse_timer_next = pulse_timer - 1'b1;
        go = (pulse_timer_next == '0);
      end
      if (go && step_level) begin
        step_level_next  = 1'b0;
        pulse_timer_next = (phase == PH_RELEASE) ? release_gap_ticks : seek_gap_ticks;
        go = (pulse_timer_next == '0);
      end
      if (go) begin
        case (phase)
          PH_SEEK: begin
            if (trig) begin
              dir_level_next   = ~dir_level;
              pulse_timer_next = PulseLoad;
              phase_next       = PH_RELEASE;
            end else begin
              net_steps_next   = net_steps + 1'b1;
              step_level_next  = 1'b1;
              pulse_timer_next = PulseLoad;
            end
          end
          PH_RELEASE: begin
            if (trig) begin
              net_steps_next   = net_steps - 1'b1;
              step_level_next  = 1'b1;
              pulse_timer_next = PulseLoad;
            end else begin
              home_estimate_reg_next = home_to_max ? home_position - net_steps
                                                   : home_position + net_steps;
              // switch released: drop straight into the backoff decision
              if (backoff_steps != '0) begin
                backoff_left_next = backoff_steps - 1'b1;
                step_level_next   = 1'b1;
                pulse_timer_next  = PulseLoad;
                phase_next        = PH_BACKOFF;
              end else begin
                backoff_left_next = '0;
                position_reg_next = home_position + COORD_W'(backoff_steps);
                phase_next        = PH_IDLE;
                done_next         = 1'b1;
              end
            end
          end
          PH_BACKOFF: begin
            if (backoff_left != '0) begin
              backoff_left_next = backoff_left - 1'b1;
              step_level_next   = 1'b1;
              pulse_timer_next  = PulseLoad;
            end else begin
              position_reg_next = home_position + COORD_W'(backoff_steps);
              phase_next        = PH_IDLE;
              done_next         = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      dir_level         <= 1'b0;
      step_level        <= 1'b0;
      err_flag          <= 1'b0;
      pulse_timer       <= '0;
      net_steps         <= '0;
      backoff_left      <= '0;
      position_reg      <= '0;
      home_estimate_reg <= '0;
    end else if (in_fire) begin
      phase             <= phase_next;
      dir_level         <= dir_level_next;
      step_level        <= step_level_next;
      err_flag          <= err_flag_next;
      pulse_timer       <= pulse_timer_next;
      net_steps         <= net_steps_next;
      backoff_left      <= backoff_left_next;
      position_reg      <= position_reg_next;
      home_estimate_reg <= home_estimate_reg_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      step_out      <= step_level_next;
      dir_out       <= dir_level_next;
      busy_res      <= (phase_next != PH_IDLE);
      done_res      <= done_next;
      error         <= err_flag_next;
      position      <= position_reg_next;
      home_estimate <= home_estimate_reg_next;
    end
  end

  `AST_NOW(a_done_not_busy, out_valid && done_res, !busy_res)
  `AST_NOW(a_step_only_busy, out_valid && step_out, busy_res)
  `AST_NEXT(a_error_sticky, err_flag, err_flag)
  `AST_NOW(a_idle_step_low, phase == PH_IDLE, !step_level)

endmodule
